// File: hdl/dbd_pkg.sv
// Shared types and constants for the delimited block deframer.
package dbd_pkg;

  localparam int unsigned OFFSET_BITS = 20;
  localparam int unsigned SIZE_BITS   = 20;
  localparam int unsigned SEQ_BITS    = 32;

  localparam int unsigned LEN_FIRST    = 8;
  localparam int unsigned SEQ_FIRST    = 12;
  localparam int unsigned HEADER_BYTES = 16;
  localparam int unsigned TRAILER_BYTES = 8;
  localparam int unsigned OVERHEAD_BYTES = 24;
  localparam int unsigned SHORT_LIMIT  = 106;

  localparam logic [SIZE_BITS-1:0] MAX_FRAME_RESET = 20'd65536;
  localparam logic [63:0] END_MARKER = 64'h557F5A02693ED6AA;

  // Output queue between the parser and the output port
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = 1;
  localparam int unsigned QCNT_BITS   = 2;

  typedef enum logic [2:0] {
    ST_BUSY       = 3'd0,
    ST_OK         = 3'd1,
    ST_BAD_START  = 3'd2,
    ST_BAD_LENGTH = 3'd3,
    ST_BAD_END    = 3'd4,
    ST_SHORT      = 3'd5
  } status_e;

  typedef struct packed {
    logic [7:0]             out_byte;
    logic [OFFSET_BITS-1:0] frame_offset;
    logic                   in_payload;
    logic                   frame_done;
    status_e                frame_status;
    logic                   sequence_gap;
    logic [SEQ_BITS-1:0]    frame_sequence;
    logic [SIZE_BITS-1:0]   frame_total_bytes;
  } result_t;

  function automatic logic [7:0] start_byte(input logic [2:0] idx);
    logic [7:0] b;
    case (idx)
      3'd0:    b = 8'hAA;
      3'd1:    b = 8'hD6;
      3'd2:    b = 8'h3E;
      3'd3:    b = 8'h69;
      3'd4:    b = 8'h02;
      3'd5:    b = 8'h5A;
      3'd6:    b = 8'h7F;
      3'd7:    b = 8'h55;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: hdl/dbd_if.sv
// Valid/ready channel interfaces for the deframer input and result streams.
interface dbd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, output command, output data_byte, input ready);
  modport sink   (input valid, input command, input data_byte, output ready);
endinterface

interface dbd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic [19:0] frame_offset;
  logic        in_payload;
  logic        frame_done;
  logic [2:0]  frame_status;
  logic        sequence_gap;
  logic [31:0] frame_sequence;
  logic [19:0] frame_total_bytes;

  modport source (
    output valid, output out_byte, output frame_offset, output in_payload,
    output frame_done, output frame_status, output sequence_gap,
    output frame_sequence, output frame_total_bytes, input ready
  );
  modport sink (
    input valid, input out_byte, input frame_offset, input in_payload,
    input frame_done, input frame_status, input sequence_gap,
    input frame_sequence, input frame_total_bytes, output ready
  );
endinterface

// File: hdl/dbd_parse.sv
// Front end: accepts stream bytes, tracks frame position and judges header/trailer.
module dbd_parse import dbd_pkg::*; #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SIZE_BITS-1:0] cfg_wdata_i,
  dbd_in_if.sink               in_i,
  input  logic                 q_ready_i,
  output logic                 push_o,
  output result_t              res_o
);

  localparam int unsigned CMP_BITS =
      ((POSITION_BITS > SIZE_BITS) ? POSITION_BITS : SIZE_BITS) + 1;
  localparam logic [32:0] POS_SPAN = 33'd1 << POSITION_BITS;

  logic [SIZE_BITS-1:0]     max_frame_q;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [SIZE_BITS-1:0]     total_q, total_d;
  logic [31:0]              len_q, len_d;
  logic [31:0]              seq_q, seq_d;
  logic [31:0]              last_seq_q, last_seq_d;
  logic                     start_ok_q, start_ok_d;
  logic [63:0]              recent_q, recent_d;

  logic                accept;
  logic [7:0]          b;
  logic [CMP_BITS-1:0] pos_ext;
  logic [CMP_BITS-1:0] total_ext;
  logic [31:0]         len_n, seq_n;
  logic [63:0]         recent_n;
  logic                start_ok_n;
  logic                hdr_last, in_body;
  logic [32:0]         total_w, limit_w;
  logic                bad_len;
  logic                finish;

  assign accept   = in_i.valid && q_ready_i;
  assign in_i.ready = q_ready_i;
  assign push_o   = accept && !in_i.command;
  assign b        = in_i.data_byte;

  assign pos_ext   = CMP_BITS'(pos_q);
  assign total_ext = CMP_BITS'(total_q);
  assign hdr_last  = pos_ext == CMP_BITS'(HEADER_BYTES - 1);
  assign in_body   = pos_ext >= CMP_BITS'(HEADER_BYTES);

  assign recent_n   = {recent_q[55:0], b};
  assign start_ok_n = start_ok_q &&
      !((pos_ext < CMP_BITS'(LEN_FIRST)) && (b != start_byte(pos_q[2:0])));
  assign len_n = ((pos_ext >= CMP_BITS'(LEN_FIRST)) && (pos_ext < CMP_BITS'(SEQ_FIRST)))
               ? {len_q[23:0], b} : len_q;
  assign seq_n = ((pos_ext >= CMP_BITS'(SEQ_FIRST)) && (pos_ext < CMP_BITS'(HEADER_BYTES)))
               ? {seq_q[23:0], b} : seq_q;

  // Size limit is the smaller of the register and the position counter span
  assign total_w = {1'b0, len_n} + 33'(OVERHEAD_BYTES);
  assign limit_w = (33'(max_frame_q) > POS_SPAN) ? POS_SPAN : 33'(max_frame_q);
  assign bad_len = len_n[31] || (total_w > limit_w);

  always_comb begin
    res_o = '0;
    res_o.out_byte     = b;
    res_o.frame_offset = pos_ext[OFFSET_BITS-1:0];
    res_o.frame_status = ST_BUSY;
    finish = 1'b0;
    if (hdr_last) begin
      if (!start_ok_n) begin
        res_o.frame_status = ST_BAD_START;
        finish = 1'b1;
      end else begin
        res_o.frame_sequence = seq_n;
        res_o.sequence_gap   = seq_n != (last_seq_q + 32'd1);
        if (bad_len) begin
          res_o.frame_status = ST_BAD_LENGTH;
          finish = 1'b1;
        end else begin
          res_o.frame_total_bytes = total_w[SIZE_BITS-1:0];
        end
      end
    end else if (in_body) begin
      res_o.frame_sequence    = seq_q;
      res_o.frame_total_bytes = total_q;
      res_o.in_payload = (pos_ext + CMP_BITS'(TRAILER_BYTES)) < total_ext;
      if ((pos_ext + CMP_BITS'(1)) >= total_ext) begin
        finish = 1'b1;
        if (recent_n != END_MARKER) begin
          res_o.frame_status = ST_BAD_END;
        end else if (total_ext < CMP_BITS'(SHORT_LIMIT)) begin
          res_o.frame_status = ST_SHORT;
        end else begin
          res_o.frame_status = ST_OK;
        end
      end
    end
    res_o.frame_done = finish;
  end

  always_comb begin
    pos_d      = pos_q;
    total_d    = total_q;
    len_d      = len_q;
    seq_d      = seq_q;
    last_seq_d = last_seq_q;
    start_ok_d = start_ok_q;
    recent_d   = recent_q;
    if (accept) begin
      if (in_i.command || finish) begin
        pos_d      = '0;
        total_d    = '0;
        len_d      = '0;
        seq_d      = '0;
        start_ok_d = 1'b1;
        recent_d   = '0;
        if (in_i.command) begin
          last_seq_d = '0;
        end else if (hdr_last && start_ok_n && !bad_len) begin
          last_seq_d = seq_n;
        end
      end else begin
        pos_d      = pos_q + POSITION_BITS'(1);
        len_d      = len_n;
        seq_d      = seq_n;
        start_ok_d = start_ok_n;
        recent_d   = recent_n;
        if (hdr_last) begin
          last_seq_d = seq_n;
          total_d    = total_w[SIZE_BITS-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_frame_q <= MAX_FRAME_RESET;
      pos_q       <= '0;
      total_q     <= '0;
      len_q       <= '0;
      seq_q       <= '0;
      last_seq_q  <= '0;
      start_ok_q  <= 1'b1;
      recent_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        max_frame_q <= cfg_wdata_i;
      end
      pos_q      <= pos_d;
      total_q    <= total_d;
      len_q      <= len_d;
      seq_q      <= seq_d;
      last_seq_q <= last_seq_d;
      start_ok_q <= start_ok_d;
      recent_q   <= recent_d;
    end
  end

`ifndef SYNTH
  a_done_has_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.frame_done |-> res_o.frame_status != ST_BUSY)
    else $error("frame end without a final status");
  a_busy_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && !res_o.frame_done |-> res_o.frame_status == ST_BUSY)
    else $error("final status on a byte that does not end the frame");
  a_gap_on_header: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.sequence_gap |-> res_o.frame_offset == OFFSET_BITS'(HEADER_BYTES - 1))
    else $error("sequence gap outside header completion");
  a_restart_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && res_o.frame_done |=> pos_q == '0 && start_ok_q)
    else $error("frame position not rewound after frame end");
`endif

endmodule

// File: hdl/dbd_queue.sv
// Back end: short result queue that drives the output channel.
module dbd_queue import dbd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t res_i,
  output logic    ready_o,
  dbd_out_if.source out_o
);

  result_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_q, rd_q;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;
  logic                 pop;
  result_t              head;

  assign ready_o = cnt_q != QCNT_BITS'(QUEUE_DEPTH);
  assign pop     = out_o.valid && out_o.ready;
  assign head    = mem_q[rd_q];

  assign out_o.valid             = cnt_q != '0;
  assign out_o.out_byte          = head.out_byte;
  assign out_o.frame_offset      = head.frame_offset;
  assign out_o.in_payload        = head.in_payload;
  assign out_o.frame_done        = head.frame_done;
  assign out_o.frame_status      = head.frame_status;
  assign out_o.sequence_gap      = head.sequence_gap;
  assign out_o.frame_sequence    = head.frame_sequence;
  assign out_o.frame_total_bytes = head.frame_total_bytes;

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + QCNT_BITS'(1);
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - QCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QPTR_BITS'(1);
      end
      if (pop) begin
        rd_q <= rd_q + QPTR_BITS'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: hdl/delimited_block_deframer_top.sv
// Delimited block deframer: top level joining the parser and the result queue.
//
// in_i carries one byte (or a reconnect command) per transfer; out_o carries
// one result per data byte, tagged with its frame offset, payload flag, end
// flag, status, sequence gap, sequence number and total frame size.
// A reconnect command gives no result; it clears the stored sequence number
// and rewinds the frame position.
// max_frame_bytes is written through cfg_we_i/cfg_wdata_i; the user must
// write it only while idle; the block has no check for it. One byte is taken
// per cycle while in_i.ready is high; the parser judges each byte in the cycle
// it arrives, against its frame counters, and the queue registers the result.
// A two-entry result queue separates in_i from out_o; when the receiver
// stalls the queue fills and in_i.ready drops until an entry is taken.
// Reset clears the frame position, the stored sequence number and the queue,
// and sets max_frame_bytes to 65536.
module delimited_block_deframer_top import dbd_pkg::*; #(
  parameter int unsigned POSITION_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [SIZE_BITS-1:0] cfg_wdata_i,
  dbd_in_if.sink               in_i,
  dbd_out_if.source            out_o
);

  logic    q_ready;
  logic    push;
  result_t res;

  dbd_parse #(
    .POSITION_BITS (POSITION_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .q_ready_i   (q_ready),
    .push_o      (push),
    .res_o       (res)
  );

  dbd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .ready_o (q_ready),
    .out_o   (out_o)
  );

endmodule

// File: tb/tb.sv
// Self-checking bench for the delimited block deframer: directed and random framed byte streams vs a predictor.
`timescale 1ns / 1ps

module tb;
  import dbd_pkg::*;

  localparam logic [63:0] START_MARKER   = 64'hAAD63E69025A7F55;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 64;

  typedef struct {
    logic       command;
    logic [7:0] data_byte;
  } stream_item_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i;
  logic [SIZE_BITS-1:0] cfg_wdata_i;

  dbd_in_if  in_if ();
  dbd_out_if out_if ();

  delimited_block_deframer_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #4 clk_i = ~clk_i;

  // Byte stream waiting to be sent, and results owed by the deframer
  stream_item_t byte_queue [$];
  result_t      results_due [$];
  stream_item_t next_item;
  result_t      want;

  // Deframer state as predicted
  logic [OFFSET_BITS-1:0] mf_pos = '0;
  logic [SIZE_BITS-1:0]   mf_total = '0;
  logic [31:0]            mf_len = '0;
  logic [31:0]            mf_seq = '0;
  logic [31:0]            mf_last_seq = '0;
  logic                   mf_start_ok = 1'b1;
  logic [63:0]            mf_tail = '0;
  logic [SIZE_BITS-1:0]   mf_max = MAX_FRAME_RESET;

  // Stimulus side
  logic [31:0] gen_seq = '0;
  int unsigned phase_items = 0;
  logic        calm = 1'b0;

  int unsigned mismatches = 0;
  int unsigned transfers_in = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned ends_by_status [8] = '{default: 0};

  function automatic void clear_frame();
    mf_pos      = '0;
    mf_total    = '0;
    mf_len      = '0;
    mf_seq      = '0;
    mf_start_ok = 1'b1;
    mf_tail     = '0;
  endfunction

  function automatic void deframe_step(input logic cmd, input logic [7:0] b);
    result_t     r;
    logic [63:0] total;
    logic        finish;
    int          p;
    if (cmd) begin
      mf_last_seq = '0;
      clear_frame();
      return;
    end
    r = '0;
    r.frame_status = ST_BUSY;
    finish = 1'b0;
    p = int'(mf_pos);
    mf_tail = {mf_tail[55:0], b};
    if (p < 8) begin
      if (b != START_MARKER[63-8*p -: 8]) mf_start_ok = 1'b0;
    end else if (p < 12) begin
      mf_len = {mf_len[23:0], b};
    end else if (p < 16) begin
      mf_seq = {mf_seq[23:0], b};
    end
    if (p == 15) begin
      if (!mf_start_ok) begin
        r.frame_status = ST_BAD_START;
        finish = 1'b1;
      end else begin
        total = {32'd0, mf_len} + 64'd24;
        r.frame_sequence = mf_seq;
        r.sequence_gap = (mf_seq != mf_last_seq + 32'd1);
        // negative length as signed, or total frame size above the configured size
        if (mf_len[31] || total > {44'd0, mf_max}) begin
          r.frame_status = ST_BAD_LENGTH;
          finish = 1'b1;
        end else begin
          mf_last_seq = mf_seq;
          mf_total = total[19:0];
          r.frame_total_bytes = total[19:0];
        end
      end
    end else if (p >= 16) begin
      r.frame_sequence = mf_seq;
      r.frame_total_bytes = mf_total;
      r.in_payload = ({12'd0, mf_pos} + 32'd8 < {12'd0, mf_total});
      if ({12'd0, mf_pos} + 32'd1 >= {12'd0, mf_total}) begin
        if (mf_tail != END_MARKER) r.frame_status = ST_BAD_END;
        else if (mf_total < SHORT_LIMIT) r.frame_status = ST_SHORT;
        else r.frame_status = ST_OK;
        finish = 1'b1;
      end
    end
    r.out_byte = b;
    r.frame_offset = mf_pos;
    r.frame_done = finish;
    results_due.push_back(r);
    if (finish) clear_frame();
    else mf_pos = mf_pos + 1'b1;
  endfunction

  function automatic logic idle_now();
    return !calm && ($urandom_range(99) < 37);
  endfunction

  function automatic void check_field(input string field, input logic [31:0] want_v,
                                      input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0h, got %0h", field, want_v, got_v);
      mismatches++;
    end
  endfunction

  // Sender
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid     <= 1'b0;
      in_if.command   <= 1'b0;
      in_if.data_byte <= 8'h00;
    end else begin
      if (in_if.valid && in_if.ready) begin
        deframe_step(in_if.command, in_if.data_byte);
        transfers_in++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (byte_queue.size() != 0 && !idle_now()) begin
          next_item = byte_queue.pop_front();
          in_if.valid     <= 1'b1;
          in_if.command   <= next_item.command;
          in_if.data_byte <= next_item.data_byte;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver and checker
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $error("result with no byte waiting for it: offset %0d", out_if.frame_offset);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("out_byte", want.out_byte, out_if.out_byte);
          check_field("frame_offset", want.frame_offset, out_if.frame_offset);
          check_field("in_payload", want.in_payload, out_if.in_payload);
          check_field("frame_done", want.frame_done, out_if.frame_done);
          check_field("frame_status", want.frame_status, out_if.frame_status);
          check_field("sequence_gap", want.sequence_gap, out_if.sequence_gap);
          check_field("frame_sequence", want.frame_sequence, out_if.frame_sequence);
          check_field("frame_total_bytes", want.frame_total_bytes, out_if.frame_total_bytes);
          if (want.frame_done) ends_by_status[want.frame_status]++;
        end
      end
      out_if.ready <= !idle_now();
    end
  end

  // Watchdog: cycles with no transfer on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("no transfer for %0d cycles, %0d results outstanding", quiet_cycles,
               results_due.size());
        $display("end of test: mismatches");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_item(input logic cmd, input logic [7:0] b);
    stream_item_t it;
    it.command = cmd;
    it.data_byte = b;
    byte_queue.push_back(it);
    phase_items++;
  endtask

  // Sends the first 'cut' bytes of a frame; the byte at flip_at gets corrupted
  task automatic push_frame(input logic [31:0] seq, input logic [31:0] len, input int cut,
                            input int flip_at);
    logic [63:0] total;
    logic [7:0]  b;
    int          trailer_at;
    total = {32'd0, len} + 64'd24;
    trailer_at = int'(total[31:0]) - 8;
    for (int o = 0; o < cut; o++) begin
      if (o < 8) b = START_MARKER[63-8*o -: 8];
      else if (o < 12) b = len[31-8*(o-8) -: 8];
      else if (o < 16) b = seq[31-8*(o-12) -: 8];
      else if (o >= trailer_at) b = END_MARKER[63-8*(o-trailer_at) -: 8];
      else b = 8'($urandom);
      if (o == flip_at) b = b ^ 8'($urandom_range(1, 255));
      push_item(1'b0, b);
    end
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_if.valid || results_due.size() != 0)
      @(negedge clk_i);
    // a trailing reconnect gives no result; let it clear the block
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_max_frame(input logic [SIZE_BITS-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mf_max = v;
  endtask

  task automatic random_frame();
    int          pick;
    int          cut;
    logic [31:0] len;
    logic [31:0] seq;
    logic [31:0] len_cap;
    pick = $urandom_range(99);
    case ($urandom_range(9))
      0:       seq = $urandom;
      1:       seq = gen_seq;
      default: seq = gen_seq + 32'd1;
    endcase
    case ($urandom_range(9))
      0, 1, 2, 3, 4: len = $urandom_range(0, 20);
      5, 6, 7:       len = $urandom_range(70, 100);
      default:       len = $urandom_range(0, 140);
    endcase
    len_cap = {12'd0, mf_max} - 32'd24;
    if (len > len_cap) len = len_cap;
    if (pick < 70) begin
      push_frame(seq, len, int'(len) + 24, -1);
      gen_seq = seq;
    end else if (pick < 78) begin
      push_frame(seq, len, int'(len) + 24, $urandom_range(int'(len) + 16, int'(len) + 23));
      gen_seq = seq;
    end else if (pick < 84) begin
      push_frame(seq, len, 16, $urandom_range(0, 7));
    end else if (pick < 89) begin
      if ($urandom_range(1)) len = 32'h8000_0000 | $urandom;
      else len = {12'd0, mf_max} - 32'd23 + $urandom_range(0, 1000);
      push_frame(seq, len, 16, -1);
    end else if (pick < 94) begin
      // cut the frame short with a reconnect
      cut = $urandom_range(0, int'(len) + 23);
      push_frame(seq, len, cut, -1);
      push_item(1'b1, 8'($urandom));
      gen_seq = '0;
    end else begin
      cut = $urandom_range(1, 20);
      for (int i = 0; i < cut; i++) push_item(1'b0, 8'($urandom));
      push_item(1'b1, 8'($urandom));
      gen_seq = '0;
    end
  endtask

  task automatic random_phase();
    phase_items = 0;
    while (phase_items < PHASE_ITEMS) random_frame();
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.command   = 1'b0;
    in_if.data_byte = 8'h00;
    out_if.ready    = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: statuses, sequence wrap, length limits, reconnects
    push_frame(32'd1, 32'd0, 24, -1);             // shortest frame, short status
    push_frame(32'd2, 32'd82, 106, -1);           // exactly at the short limit
    push_frame(32'hFFFF_FFFF, 32'd5, 29, -1);     // sequence jump
    push_frame(32'd0, 32'd90, 114, -1);           // sequence wraps to zero, no gap
    push_frame(32'd1, 32'd10, 34, 33);            // bad end on the last byte
    push_frame(32'd2, 32'd0, 16, 0);              // bad start on first marker byte
    push_frame(32'd2, 32'd0, 16, 7);              // bad start on last marker byte
    push_frame(32'd2, 32'h8000_0000, 16, -1);     // negative length
    push_frame(32'd7, 32'hFFFF_FFFF, 16, -1);
    push_frame(32'd2, 32'd65513, 16, -1);         // one past the reset limit
    push_frame(32'd2, 32'd65512, 20, -1);         // at the limit, then abandoned
    push_item(1'b1, 8'hFF);
    push_frame(32'd1, 32'd3, 5, -1);              // reconnect inside the header
    push_item(1'b1, 8'h00);
    push_item(1'b0, 8'h00);
    push_item(1'b0, 8'hFF);
    push_item(1'b1, 8'h5A);
    push_frame(32'd1, 32'd1, 25, -1);

    write_max_frame(SIZE_BITS'(24));
    push_frame(32'd2, 32'd0, 24, -1);
    push_frame(32'd3, 32'd1, 16, -1);

    write_max_frame(SIZE_BITS'(1048575));
    push_frame(32'd3, 32'd1048551, 40, -1);       // largest size accepted
    push_item(1'b1, 8'h00);
    push_frame(32'd1, 32'd1048552, 16, -1);
    push_frame(32'd1, 32'd100, 124, -1);
    gen_seq = 32'd1;

    // Random phases under several limits; each write drains the pipe first
    random_phase();
    write_max_frame(SIZE_BITS'(106));
    random_phase();
    write_max_frame(SIZE_BITS'($urandom_range(24, 300)));
    calm = 1'b1;
    random_phase();
    wait_drained();
    calm = 1'b0;
    write_max_frame(MAX_FRAME_RESET);
    random_phase();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("covered %0d input transfers and %0d checked results under several size limits",
             transfers_in, results_seen);
    $display("frame ends: ok %0d, short %0d, bad start %0d, bad length %0d, bad end %0d",
             ends_by_status[ST_OK], ends_by_status[ST_SHORT], ends_by_status[ST_BAD_START],
             ends_by_status[ST_BAD_LENGTH], ends_by_status[ST_BAD_END]);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
